// ----- rtl/core/sms_pkg.sv -----
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and constants of the serial meter command slave.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int          CFG_IDX_W     = 8;
  localparam int          CNT_W         = 24;
  localparam int          BCD_W         = 28;
  localparam int          BCD_STEPS     = 24;
  localparam logic [23:0] COUNT_MAX     = 24'd9999999;
  localparam logic [7:0]  STATUS_BYTE   = 8'h20;
  localparam logic [7:0]  REG_DATA_CODE = 8'd0;
  localparam logic [7:0]  REG_ACK_CODE  = 8'd1;

  localparam logic [3:0][7:0] VERSION_TXT = {8'h00, 8'h45, 8'h32, 8'h30};
  localparam logic [3:0][7:0] FPRINT_TXT  = {8'h11, 8'h01, 8'h00, 8'h00};

  typedef enum logic [3:0] {
    C_NONE, C_STATUS, C_MARKET, C_ERROR, C_VERSION, C_COUNT, C_LASTID,
    C_FPRINT, C_SETMKT, C_INC50, C_INC51, C_INC52, C_ACK
  } cmd_class_t;

  typedef struct packed {
    logic step;
    logic mem_rd;
    logic upd;
    logic bcd_load;
    logic bcd_step;
    logic build;
  } sms_cmd_t;

  typedef struct packed {
    logic       frame_end;
    cmd_class_t cls;
  } sms_stat_t;

  function automatic cmd_class_t cmd_class(input logic [7:0] c);
    cmd_class_t k;
    unique case (c)
      8'h20: k = C_STATUS;
      8'h21: k = C_MARKET;
      8'h22: k = C_ERROR;
      8'h23: k = C_VERSION;
      8'h24: k = C_COUNT;
      8'h25: k = C_LASTID;
      8'h26: k = C_FPRINT;
      8'h31: k = C_SETMKT;
      8'h50: k = C_INC50;
      8'h51: k = C_INC51;
      8'h52: k = C_INC52;
      8'h30, 8'h32, 8'h40, 8'h41, 8'h42, 8'h43, 8'h54, 8'h55, 8'h5C: k = C_ACK;
      default: k = C_NONE;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/core/sms_if.sv -----
// ----------------------------------------------------------------------------
// sms channel interfaces
// Valid/ready channels for pin samples, reply results and register writes.
// ----------------------------------------------------------------------------
interface sms_in_if;
  logic valid;
  logic ready;
  logic enable_pin;
  logic clock_pin;
  logic data_pin;
  modport source(output valid, enable_pin, clock_pin, data_pin, input ready);
  modport sink(input valid, enable_pin, clock_pin, data_pin, output ready);
endinterface

interface sms_out_if;
  logic valid;
  logic ready;
  logic data_out;
  logic frame_done;
  logic checksum_bad;
  modport source(output valid, data_out, frame_done, checksum_bad, input ready);
  modport sink(input valid, data_out, frame_done, checksum_bad, output ready);
endinterface

interface sms_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sms_pkg::CFG_IDX_W-1:0]  index;
  logic [7:0]                     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/sms_ctrl.sv -----
// ----------------------------------------------------------------------------
// sms_ctrl
// Sequencer: takes pin items, runs frame decode steps, owns result valid.
// ----------------------------------------------------------------------------
module sms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sms_pkg::sms_stat_t  stat,
  output sms_pkg::sms_cmd_t   cmd
);
  import sms_pkg::*;

  localparam int CW = $clog2(BCD_STEPS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD    = 5'b00010,
    S_MEM   = 5'b00100,
    S_BCD   = 5'b01000,
    S_BUILD = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          is_inc;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign is_inc    = (stat.cls == C_INC50) || (stat.cls == C_INC51) ||
                     (stat.cls == C_INC52);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.step = 1'b1;
          if (stat.frame_end) state_nxt = S_RD;
          else out_valid_nxt = 1'b1;
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_MEM;
      end
      S_MEM: begin
        cmd.upd = is_inc;
        if (stat.cls == C_COUNT) begin
          cmd.bcd_load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_BCD;
        end else begin
          state_nxt = S_BUILD;
        end
      end
      S_BCD: begin
        cmd.bcd_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CW'(BCD_STEPS - 1)) state_nxt = S_BUILD;
      end
      S_BUILD: begin
        cmd.build     = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BCD) |-> (cnt_r < CW'(BCD_STEPS)))
    else $error("bcd step count out of range");
  a_frame_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && stat.frame_end) |=> (state_r == S_RD))
    else $error("frame end did not start decode");
  a_build_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BUILD) |-> !out_valid_r)
    else $error("result slot busy at reply build");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE))
    else $error("ready outside idle");
`endif

endmodule

// ----- rtl/core/sms_datapath.sv -----
// ----------------------------------------------------------------------------
// sms_datapath
// Link state, frame bytes, reply buffer, meter memory and BCD converter.
// ----------------------------------------------------------------------------
module sms_datapath #(
  parameter int NUM_METERS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sms_pkg::sms_cmd_t               cmd,
  output sms_pkg::sms_stat_t              stat,
  input  logic                            in_enable_pin,
  input  logic                            in_clock_pin,
  input  logic                            in_data_pin,
  input  logic                            cfg_we,
  input  logic [sms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_data,
  output logic                            out_data_out,
  output logic                            out_frame_done,
  output logic                            out_checksum_bad
);
  import sms_pkg::*;

  localparam int AW = (NUM_METERS > 1) ? $clog2(NUM_METERS) : 1;

  // link state
  logic       en_r, en_nxt;
  logic       dout_r, dout_nxt;
  logic       cprev_r, cprev_nxt;
  logic [2:0] bitcnt_r, bitcnt_nxt;
  logic [7:0] shin_r, shin_nxt;
  logic [8:0] fpos_r, fpos_nxt;
  logic [8:0] brem_r, brem_nxt;
  logic [7:0] rsum_r, rsum_nxt;
  logic [3:0] rbit_r, rbit_nxt;
  logic [3:0] rleft_r, rleft_nxt;
  logic [2:0] ridx_r, ridx_nxt;
  logic [8:0] fidx;
  logic       take, fin, bad, rsh;
  logic       bad_r;

  logic [7:0] rbytes_r [8];
  logic [7:0] b0_r, b1_r, b3_r, b4_r, b5_r;
  logic [7:0] data_code_r, ack_code_r, market_r, last_id_r;

  // ---------------- pin item step ----------------
  always_comb begin
    en_nxt     = en_r;
    dout_nxt   = dout_r;
    cprev_nxt  = cprev_r;
    bitcnt_nxt = bitcnt_r;
    shin_nxt   = shin_r;
    fpos_nxt   = fpos_r;
    brem_nxt   = brem_r;
    rsum_nxt   = rsum_r;
    rbit_nxt   = rbit_r;
    rleft_nxt  = rleft_r;
    ridx_nxt   = ridx_r;
    fidx       = fpos_r;
    take       = 1'b0;
    fin        = 1'b0;
    bad        = 1'b0;
    rsh        = 1'b0;
    if (in_enable_pin) begin
      if (!en_nxt) begin
        en_nxt   = 1'b1;
        dout_nxt = 1'b0;
      end
    end else begin
      if (en_nxt) dout_nxt = 1'b1;
      en_nxt     = 1'b0;
      cprev_nxt  = 1'b1;
      bitcnt_nxt = '0;
      shin_nxt   = '0;
      fpos_nxt   = '0;
      rbit_nxt   = '0;
      rleft_nxt  = '0;
      ridx_nxt   = '0;
    end
    if (in_clock_pin != cprev_nxt) begin
      if (!in_clock_pin) begin
        shin_nxt = {shin_nxt[6:0], in_data_pin};
        if (rbit_nxt == 4'd8) begin
          rbit_nxt  = '0;
          ridx_nxt  = ridx_nxt + 3'd1;
          rleft_nxt = rleft_nxt - 4'd1;
        end
        if (rleft_nxt != '0) dout_nxt = rbytes_r[ridx_nxt][7];
        else dout_nxt = ~en_nxt;
      end else begin
        bitcnt_nxt = bitcnt_nxt + 3'd1;
        if (rleft_nxt != '0) begin
          rsh      = 1'b1;
          rbit_nxt = rbit_nxt + 4'd1;
        end
        if (bitcnt_nxt == '0 && rleft_nxt == '0) begin
          take = 1'b1;
          fidx = fpos_nxt;
          if (fpos_nxt == '0) rsum_nxt = '0;
          fpos_nxt = fpos_nxt + 9'd1;
          if (brem_nxt != '0) begin
            brem_nxt = brem_nxt - 9'd1;
            if (brem_nxt == '0) fin = 1'b1;
          end
          if (fin) begin
            bad      = (rsum_nxt != shin_nxt);
            fpos_nxt = '0;
          end else begin
            rsum_nxt = rsum_nxt + shin_nxt;
          end
          if (fpos_nxt == 9'd3) brem_nxt = {1'b0, shin_nxt} + 9'd1;
        end
      end
      cprev_nxt = in_clock_pin;
    end
  end

  assign stat.frame_end = fin;
  assign stat.cls       = cmd_class(b0_r);

  // ---------------- meter memory ----------------
  logic [CNT_W-1:0]      mem [NUM_METERS];
  logic [NUM_METERS-1:0] vld_r;
  logic [CNT_W-1:0]      rd_q;
  logic                  vld_q;
  logic [AW-1:0]         maddr;
  logic                  inrng;
  logic [CNT_W-1:0]      count;
  logic [15:0]           amt;
  logic [CNT_W:0]        sum_c;
  logic [CNT_W-1:0]      sat;

  assign maddr = b3_r[AW-1:0];
  assign inrng = ({1'b0, b3_r} < 9'(NUM_METERS));
  assign count = vld_q ? rd_q : '0;

  always_comb begin
    unique case (stat.cls)
      C_INC50: amt = {12'd0, b4_r[3:0]};
      C_INC51: amt = {8'd0, b4_r};
      default: amt = {b5_r, b4_r};
    endcase
  end

  assign sum_c = {1'b0, count} + {9'd0, amt};
  assign sat   = (sum_c > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum_c[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) rd_q <= mem[maddr];
    if (cmd.upd && inrng) mem[maddr] <= sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      vld_q <= 1'b0;
    end else begin
      if (cmd.mem_rd) vld_q <= vld_r[maddr] && inrng;
      if (cmd.upd && inrng) vld_r[maddr] <= 1'b1;
    end
  end

  // ---------------- double-dabble, one bit per cycle ----------------
  logic [BCD_W-1:0] bcd_r, bcd_adj;
  logic [CNT_W-1:0] bin_r;

  always_comb begin
    for (int i = 0; i < BCD_W / 4; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                    : bcd_r[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bcd_load) begin
      bcd_r <= '0;
      bin_r <= count;
    end else if (cmd.bcd_step) begin
      bcd_r <= {bcd_adj[BCD_W-2:0], bin_r[CNT_W-1]};
      bin_r <= {bin_r[CNT_W-2:0], 1'b0};
    end
  end

  // ---------------- reply assembly ----------------
  logic [7:0]      r_code, r_sum;
  logic [2:0]      r_len;
  logic [3:0][7:0] r_dat;
  logic            r_has;
  logic [31:0]     bcd_word;

  assign bcd_word = {bcd_r, 4'h0};

  always_comb begin
    r_code = ack_code_r;
    r_len  = 3'd0;
    r_dat  = '0;
    r_has  = 1'b1;
    unique case (stat.cls)
      C_STATUS:  begin r_code = data_code_r; r_len = 3'd1; r_dat[0] = STATUS_BYTE; end
      C_MARKET:  begin r_code = data_code_r; r_len = 3'd1; r_dat[0] = market_r; end
      C_ERROR:   begin r_code = data_code_r; r_len = 3'd1; end
      C_VERSION: begin r_code = data_code_r; r_len = 3'd3; r_dat = VERSION_TXT; end
      C_COUNT: begin
        r_code   = data_code_r;
        r_len    = 3'd4;
        r_dat[0] = bcd_word[31:24];
        r_dat[1] = bcd_word[23:16];
        r_dat[2] = bcd_word[15:8];
        r_dat[3] = bcd_word[7:0];
      end
      C_LASTID:  begin r_code = data_code_r; r_len = 3'd4; r_dat[0] = last_id_r; end
      C_FPRINT:  begin r_code = data_code_r; r_len = 3'd4; r_dat = FPRINT_TXT; end
      C_NONE:    r_has = 1'b0;
      default:   r_has = 1'b1;
    endcase
    r_sum = r_code + last_id_r + {5'd0, r_len} + r_dat[0] + r_dat[1] + r_dat[2] +
            r_dat[3];
  end

  always_ff @(posedge clk) begin
    if (cmd.build && r_has) begin
      rbytes_r[0] <= r_code;
      rbytes_r[1] <= last_id_r;
      rbytes_r[2] <= {5'd0, r_len};
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < r_len) rbytes_r[3 + i] <= r_dat[i];
      end
      rbytes_r[3'd3 + r_len] <= r_sum;
    end else if (cmd.step && rsh) begin
      rbytes_r[ridx_r] <= {rbytes_r[ridx_r][6:0], 1'b0};
    end
  end

  // frame bytes; only the ones decode looks at are kept
  always_ff @(posedge clk) begin
    if (cmd.step && take) begin
      if (fidx == 9'd0) b0_r <= shin_nxt;
      if (fidx == 9'd1) b1_r <= shin_nxt;
      if (fidx == 9'd3) b3_r <= shin_nxt;
      if (fidx == 9'd4) b4_r <= shin_nxt;
      if (fidx == 9'd5) b5_r <= shin_nxt;
    end
    if (cmd.step) bad_r <= bad;
  end

  // ---------------- control and link registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      dout_r      <= 1'b0;
      cprev_r     <= 1'b1;
      bitcnt_r    <= '0;
      shin_r      <= '0;
      fpos_r      <= '0;
      brem_r      <= '0;
      rsum_r      <= '0;
      rbit_r      <= '0;
      rleft_r     <= '0;
      ridx_r      <= '0;
      market_r    <= '0;
      last_id_r   <= '0;
      data_code_r <= 8'd1;
      ack_code_r  <= 8'd6;
    end else begin
      if (cmd.step) begin
        en_r     <= en_nxt;
        dout_r   <= dout_nxt;
        cprev_r  <= cprev_nxt;
        bitcnt_r <= bitcnt_nxt;
        shin_r   <= shin_nxt;
        fpos_r   <= fpos_nxt;
        brem_r   <= brem_nxt;
        rsum_r   <= rsum_nxt;
        rbit_r   <= rbit_nxt;
        rleft_r  <= rleft_nxt;
        ridx_r   <= ridx_nxt;
      end
      if (cmd.mem_rd) last_id_r <= b1_r;
      if (cmd.build) begin
        if (stat.cls == C_SETMKT) market_r <= b3_r;
        if (r_has) begin
          ridx_r  <= '0;
          rbit_r  <= '0;
          rleft_r <= 4'd4 + {1'b0, r_len};
        end
      end
      if (cfg_we && cfg_index == REG_DATA_CODE) data_code_r <= cfg_data;
      if (cfg_we && cfg_index == REG_ACK_CODE)  ack_code_r  <= cfg_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.step && !fin) begin
      out_data_out     <= dout_nxt;
      out_frame_done   <= 1'b0;
      out_checksum_bad <= 1'b0;
    end else if (cmd.build) begin
      out_data_out     <= dout_r;
      out_frame_done   <= 1'b1;
      out_checksum_bad <= bad_r;
    end
  end

endmodule

// ----- rtl/core/serial_meter_command_slave_core.sv -----
// ----------------------------------------------------------------------------
// serial_meter_command_slave_core
// Pin-sampling slave that decodes meter command frames and shifts out replies.
// ----------------------------------------------------------------------------
// Pin items: one can be taken every cycle while results drain and no frame is being decoded.
// An item that ends a frame runs the read, memory and build steps, and for a counter read
// also the 24-step serial binary-to-BCD converter between memory and build.
// Reset (rst_n low, synchronous) clears link state, the control registers and the meter
// valid bits at once; there is no clearing pass.
module serial_meter_command_slave_core #(
  parameter int NUM_METERS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  sms_in_if.sink     in_ch,
  sms_out_if.source  out_ch,
  sms_cfg_if.sink    cfg_ch
);
  import sms_pkg::*;

  sms_cmd_t  cmd;
  sms_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  sms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sms_datapath #(
    .NUM_METERS (NUM_METERS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_enable_pin    (in_ch.enable_pin),
    .in_clock_pin     (in_ch.clock_pin),
    .in_data_pin      (in_ch.data_pin),
    .cfg_we           (cfg_ch.valid && cfg_ch.ready),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .out_data_out     (out_ch.data_out),
    .out_frame_done   (out_ch.frame_done),
    .out_checksum_bad (out_ch.checksum_bad)
  );

endmodule

// ----- tb/sv/tb_sms_scoreboard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms reply scoreboard
// Holds pending reply pin samples and compares them with the block's output.
// ----------------------------------------------------------------------------
typedef struct packed {
  logic data_out;
  logic frame_done;
  logic checksum_bad;
} pin_result_t;

class sms_reply_board;
  pin_result_t pending[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned frames_seen;
  int unsigned bad_sums_seen;

  function void note_sample(pin_result_t r);
    pending.push_back(r);
  endfunction

  function void check_sample(pin_result_t got);
    pin_result_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result with nothing pending: %b%b%b",
                 got.data_out, got.frame_done, got.checksum_bad);
      return;
    end
    want = pending.pop_front();
    checked++;
    if (got.frame_done) frames_seen++;
    if (got.checksum_bad) bad_sums_seen++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: sample %0d data_out %b/%b frame_done %b/%b checksum_bad %b/%b",
                 checked, want.data_out, got.data_out, want.frame_done,
                 got.frame_done, want.checksum_bad, got.checksum_bad);
    end
  endfunction
endclass

// ----- tb/sv/tb_serial_meter_command_slave_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_meter_command_slave_core
// Bit-bangs command frames into the slave, predicts every pin sample's reply
// and frame flags, and checks them under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_serial_meter_command_slave_core;
  import sms_pkg::*;

  localparam int METERS    = 32;
  localparam int STORE     = 8;
  localparam int WDOG_MAX  = 20000;
  localparam logic [7:0] CMD_STATUS = 8'h20, CMD_MARKET = 8'h21, CMD_ERROR = 8'h22,
    CMD_VERSION = 8'h23, CMD_COUNT = 8'h24, CMD_LASTID = 8'h25, CMD_FPRINT = 8'h26,
    CMD_ACK30 = 8'h30, CMD_SETMKT = 8'h31, CMD_INC50 = 8'h50, CMD_INC51 = 8'h51,
    CMD_INC52 = 8'h52, CMD_ACK5C = 8'h5C;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  sms_in_if  in_ch();
  sms_out_if out_ch();
  sms_cfg_if cfg_ch();

  serial_meter_command_slave_core #(.NUM_METERS(METERS)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  sms_reply_board board = new();

  // predictor state
  logic [7:0]  data_code, ack_code;
  logic        link_on, clk_seen, pin_latch;
  logic [2:0]  bits_in;
  logic [7:0]  rx_shift;
  logic [8:0]  rx_pos, rx_left;
  logic [7:0]  rx_sum;
  logic [7:0]  rx_store [STORE];
  logic [7:0]  tx_store [8];
  logic [3:0]  tx_left;
  logic [2:0]  tx_idx;
  logic [3:0]  tx_bit;
  logic        tx_pin;
  logic [7:0]  market;
  logic [7:0]  last_id;
  logic [23:0] meters [METERS];
  logic        fr_done, fr_bad;

  int unsigned sent, accepted_out, cycles_idle;
  bit          hold_off, run_done;
  bit          quiet_out;

  function automatic logic [7:0] rx_at(int i);
    return (i < STORE) ? rx_store[i] : 8'h00;
  endfunction

  function automatic void build_reply(logic [7:0] code, int len, logic [31:0] body);
    logic [7:0] sum;
    tx_store[0] = code;
    tx_store[1] = last_id;
    tx_store[2] = len[7:0];
    for (int i = 0; i < len; i++) tx_store[3 + i] = body[31 - 8 * i -: 8];
    sum = 8'h00;
    for (int i = 0; i < 3 + len; i++) sum += tx_store[i];
    tx_store[3 + len] = sum;
    tx_idx = 3'd0;
    tx_bit = 4'd0;
    tx_left = 4'(4 + len);
  endfunction

  function automatic void bump_meter(int m, int amount);
    int v;
    if (m < METERS) begin
      v = int'(meters[m]) + amount;
      meters[m] = (v > int'(COUNT_MAX)) ? COUNT_MAX : 24'(v);
    end
  endfunction

  function automatic logic [31:0] count_as_bcd(int m);
    int v;
    logic [31:0] b;
    v = (m < METERS) ? int'(meters[m]) : 0;
    b = 32'h0;
    for (int k = 0; k < 7; k++) begin
      b[4 * (k + 1) +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return b;
  endfunction

  function automatic void run_command();
    logic [7:0] op;
    int m;
    op = rx_at(0);
    m = int'(rx_at(3));
    last_id = rx_at(1);
    case (op)
      CMD_STATUS:  build_reply(data_code, 1, {STATUS_BYTE, 24'h0});
      CMD_MARKET:  build_reply(data_code, 1, {market, 24'h0});
      CMD_ERROR:   build_reply(data_code, 1, 32'h0);
      CMD_VERSION: build_reply(data_code, 3, 32'h30324500);
      CMD_COUNT:   build_reply(data_code, 4, count_as_bcd(m));
      CMD_LASTID:  build_reply(data_code, 4, {last_id, 24'h0});
      CMD_FPRINT:  build_reply(data_code, 4, 32'h00000111);
      CMD_SETMKT: begin
        market = m[7:0];
        build_reply(ack_code, 0, 32'h0);
      end
      CMD_INC50: begin
        bump_meter(m, int'(rx_at(4) & 8'h0F));
        build_reply(ack_code, 0, 32'h0);
      end
      CMD_INC51: begin
        bump_meter(m, int'(rx_at(4)));
        build_reply(ack_code, 0, 32'h0);
      end
      CMD_INC52: begin
        bump_meter(m, int'(rx_at(4)) + 256 * int'(rx_at(5)));
        build_reply(ack_code, 0, 32'h0);
      end
      CMD_ACK30, 8'h32, 8'h40, 8'h41, 8'h42, 8'h43, 8'h54, 8'h55, CMD_ACK5C:
        build_reply(ack_code, 0, 32'h0);
      default: ;
    endcase
  endfunction

  function automatic void take_rx_byte(logic [7:0] x);
    bit last;
    last = 1'b0;
    if (rx_pos < STORE) rx_store[rx_pos] = x;
    if (rx_pos == 0) rx_sum = 8'h00;
    rx_pos = rx_pos + 9'd1;
    if (rx_left != 0) begin
      rx_left = rx_left - 9'd1;
      if (rx_left == 0) last = 1'b1;
    end
    if (last) begin
      fr_done = 1'b1;
      fr_bad = (rx_sum != x);
      run_command();
      rx_pos = 9'd0;
    end else begin
      rx_sum = rx_sum + x;
    end
    if (rx_pos == 9'd3) rx_left = {1'b0, x} + 9'd1;
  endfunction

  function automatic void drop_link();
    clk_seen = 1'b1;
    bits_in = 3'd0;
    rx_shift = 8'h00;
    rx_pos = 9'd0;
    tx_bit = 4'd0;
    tx_left = 4'd0;
    tx_idx = 3'd0;
  endfunction

  function automatic void model_reset();
    data_code = 8'd1;
    ack_code = 8'd6;
    link_on = 1'b0;
    pin_latch = 1'b0;
    rx_left = 9'd0;
    rx_sum = 8'h00;
    for (int i = 0; i < STORE; i++) rx_store[i] = 8'h00;
    for (int i = 0; i < 8; i++) tx_store[i] = 8'h00;
    tx_pin = 1'b0;
    market = 8'h00;
    last_id = 8'h00;
    for (int i = 0; i < METERS; i++) meters[i] = 24'h0;
    drop_link();
  endfunction

  function automatic pin_result_t model_sample(logic e, logic c, logic d);
    pin_result_t r;
    fr_done = 1'b0;
    fr_bad = 1'b0;
    if (e) begin
      if (!link_on) begin
        link_on = 1'b1;
        tx_pin = 1'b0;
      end
    end else begin
      if (link_on) tx_pin = 1'b1;
      link_on = 1'b0;
      drop_link();
    end
    pin_latch = d;
    if (c != clk_seen) begin
      if (!c) begin
        rx_shift = {rx_shift[6:0], pin_latch};
        if (tx_bit == 4'd8) begin
          tx_bit = 4'd0;
          tx_idx = tx_idx + 3'd1;
          tx_left = tx_left - 4'd1;
        end
        if (tx_left != 0) tx_pin = tx_store[tx_idx][7];
        else tx_pin = !link_on;
      end else begin
        bits_in = bits_in + 3'd1;
        if (tx_left != 0) begin
          tx_store[tx_idx] = tx_store[tx_idx] << 1;
          tx_bit = tx_bit + 4'd1;
        end
        if (bits_in == 0 && tx_left == 0) take_rx_byte(rx_shift);
      end
      clk_seen = c;
    end
    r.data_out = tx_pin;
    r.frame_done = fr_done;
    r.checksum_bad = fr_done & fr_bad;
    return r;
  endfunction

  // ---------------- drivers ----------------
  initial begin
    in_ch.valid = 1'b0;
    in_ch.enable_pin = 1'b0;
    in_ch.clock_pin = 1'b1;
    in_ch.data_pin = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  int burst_left = 0, gap_left = 0;

  task automatic send_pin(logic e, logic c, logic d);
    pin_result_t r;
    if (!quiet_out && gap_left > 0) begin
      in_ch.valid <= 1'b0;
      while (gap_left > 0) begin
        @(posedge clk);
        gap_left--;
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.enable_pin <= e;
    in_ch.clock_pin <= c;
    in_ch.data_pin <= d;
    do @(posedge clk); while (!in_ch.ready);
    r = model_sample(e, c, d);
    board.note_sample(r);
    sent++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(1, 40);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    end
  endtask

  // one serial bit: clock low with data, then clock high; occasional repeats
  task automatic send_bit(logic d);
    send_pin(1'b1, 1'b0, d);
    if ($urandom_range(0, 9) == 0) send_pin(1'b1, 1'b0, d);
    send_pin(1'b1, 1'b1, d);
  endtask

  task automatic send_byte(logic [7:0] b);
    for (int i = 7; i >= 0; i--) send_bit(b[i]);
  endtask

  // clock out a pending reply; stop after its last rising edge so the next
  // falling edge both ends the reply and starts the next byte in step
  task automatic clock_out_reply();
    while (tx_left != 0 && !(tx_left == 4'd1 && tx_bit == 4'd8))
      send_bit(1'($urandom_range(0, 1)));
  endtask

  task automatic send_frame(logic [7:0] op, logic [7:0] id, logic [7:0] body[$],
                            bit corrupt);
    logic [7:0] sum;
    sum = op + id + 8'(body.size());
    send_byte(op);
    send_byte(id);
    send_byte(8'(body.size()));
    foreach (body[i]) begin
      send_byte(body[i]);
      sum += body[i];
    end
    send_byte(corrupt ? sum ^ 8'(1 << $urandom_range(0, 7)) : sum);
    clock_out_reply();
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_DATA_CODE) data_code = val;
    else if (idx == REG_ACK_CODE) ack_code = val;
    @(posedge clk);
  endtask

  // enable low with a random clock, then back up with the clock idle high
  task automatic link_cycle();
    send_pin(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    send_pin(1'b0, 1'b1, 1'b1);
    send_pin(1'b1, 1'b1, 1'b0);
  endtask

  function automatic logic [7:0] pick_op();
    logic [7:0] ops[13] = '{CMD_STATUS, CMD_MARKET, CMD_ERROR, CMD_VERSION, CMD_COUNT,
      CMD_LASTID, CMD_FPRINT, CMD_ACK30, CMD_SETMKT, CMD_INC50, CMD_INC51, CMD_INC52,
      CMD_ACK5C};
    logic [7:0] misc[9] = '{8'h32, 8'h40, 8'h41, 8'h42, 8'h43, 8'h54, 8'h55, 8'h00, 8'hFF};
    if ($urandom_range(0, 5) == 0) return misc[$urandom_range(0, 8)];
    return ops[$urandom_range(0, 12)];
  endfunction

  task automatic random_frame();
    logic [7:0] body[$];
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 9) : $urandom_range(3, 5);
    body.delete();
    for (int i = 0; i < n; i++) body.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1)) body[0] = 8'($urandom_range(0, 40)); // meter index
    send_frame(pick_op(), 8'($urandom_range(0, 255)), body, $urandom_range(0, 5) == 0);
  endtask

  // ---------------- receiver / checker ----------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_sample('{out_ch.data_out, out_ch.frame_done, out_ch.checksum_bad});
      accepted_out++;
    end
    if (!rst_n || hold_off) out_ch.ready <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(1, 8);
    end
  end

  // long hold-off started from its own process
  initial begin
    hold_off = 1'b0;
    wait (sent > 600);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      cycles_idle <= 0;
    else cycles_idle <= cycles_idle + 1;
    if (rst_n && !run_done && cycles_idle > WDOG_MAX) begin
      $display("ERROR: watchdog expired, %0d results pending", board.pending.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [7:0] body[$];
    int frames_run;
    sent = 0;
    accepted_out = 0;
    cycles_idle = 0;
    run_done = 1'b0;
    quiet_out = 1'b0;
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: enable edges, large increment, counter read, out-of-range meter with a bad
    // checksum, market, unknown command
    link_cycle();
    body = '{8'd5, 8'hFF, 8'hFF};
    send_frame(CMD_INC52, 8'hFF, body, 1'b0);
    body = '{8'd5};
    send_frame(CMD_COUNT, 8'h00, body, 1'b0);
    body = '{8'd40, 8'd9};
    send_frame(CMD_INC51, 8'h10, body, 1'b1);
    body = '{8'hA5};
    send_frame(CMD_SETMKT, 8'h22, body, 1'b0);
    body.delete();
    send_frame(CMD_MARKET, 8'h33, body, 1'b0);
    send_frame(8'hFF, 8'h77, body, 1'b0);
    // drop enable mid-frame to leave a stale byte count
    send_byte(CMD_STATUS);
    send_byte(8'h01);
    send_byte(8'd3);
    send_byte(8'h00);
    link_cycle();
    for (int i = 0; i < 6; i++) send_byte(CMD_STATUS);
    clock_out_reply();

    wait_drained();
    write_reg(REG_DATA_CODE, 8'hFF);
    write_reg(REG_ACK_CODE, 8'h00);
    frames_run = 0;
    while (sent < 1500) begin
      if (frames_run == 1) begin
        quiet_out = 1'b1;
        wait_drained();
        write_reg(REG_DATA_CODE, 8'($urandom_range(0, 255)));
        write_reg(REG_ACK_CODE, 8'($urandom_range(0, 255)));
        quiet_out = 1'b0;
      end
      case ($urandom_range(0, 9))
        0: send_pin(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        1: link_cycle();
        default: random_frame();
      endcase
      frames_run++;
      if (frames_run > 160) break;
    end

    wait_drained();
    run_done = 1'b1;
    $display("Covered %0d pin samples, %0d frames, %0d bad checksums.",
             sent, board.frames_seen, board.bad_sums_seen);
    if (board.mismatches == 0 && board.pending.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
